// File: src/conv3x3_clamped_image_filter_defines.svh
// Assertion macros shared by the filter's queue and back-end modules.
`ifndef CONV3X3_CLAMPED_IMAGE_FILTER_DEFINES_SVH
`define CONV3X3_CLAMPED_IMAGE_FILTER_DEFINES_SVH

`define CCF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define CCF_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define CCF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/c3cif_pkg.sv
package c3cif_pkg;

   localparam int PIX_W   = 8;
   localparam int ROW_W   = 16;
   localparam int COL_W   = 10;
   localparam int FW_W    = 11;
   localparam int COEF_W  = 16;
   localparam int FRAC_W  = 8;
   localparam int PROD_W  = COEF_W + PIX_W + 1;
   localparam int RSUM_W  = PROD_W + 2;
   localparam int SUM_W   = RSUM_W + 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   typedef logic [2:0][2:0][PIX_W-1:0]  window_type;
   typedef logic [2:0][2:0][COEF_W-1:0] kernel_type;

   typedef struct packed {
      window_type        win;
      logic [PIX_W-1:0]  pix;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              has_int;
      logic              has_border;
      logic              corner;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } qwrite_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qread_type;

endpackage

// File: src/c3cif_ram.sv
module c3cif_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/c3cif_front.sv
module c3cif_front import c3cif_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int WW = $clog2(MAX_WIDTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [PIX_W-1:0]  pixel_in,
   input  logic              frame_start,
   input  logic [FW_W-1:0]   frame_width,
   input  logic [ROW_W-1:0]  frame_height,
   input  logic              q_full,
   output qwrite_type        q_wr
);

   localparam int XW = (CW > COL_W) ? CW : COL_W;

   logic [WW-1:0]    eff_w;
   logic [ROW_W-1:0] eff_h;
   logic             accept;

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [CW-1:0]    col_start, cur_col;
   logic [ROW_W-1:0] row_start, cur_row;
   logic             wrap_c, end_row;
   logic [ROW_W:0]   row_adv, row_inc;
   logic [WW-1:0]    col_inc;
   logic             last_col, last_row;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [CW-1:0]    s1_col_ff;
   logic             s1_int_ff, s1_border_ff, s1_corner_ff;
   logic             s1_fwd_ff, fwd_in;
   logic [PIX_W-1:0] s1_fwd_older_ff, s1_fwd_newer_ff;

   logic [2*PIX_W-1:0] rd_data;
   logic [PIX_W-1:0]   s1_top, s1_mid;
   logic               s1_needs_push, s1_adv;
   window_type         win_ff, win_in;
   logic [XW-1:0]      col_ext;

   always_comb begin
      if (frame_width < FW_W'(3)) begin
         eff_w = WW'(3);
      end else if (32'(frame_width) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(frame_width);
      end
      eff_h = (frame_height < ROW_W'(3)) ? ROW_W'(3) : frame_height;
   end

   assign s1_needs_push = s1_int_ff || s1_border_ff;
   assign s1_adv        = s1_valid_ff && !(s1_needs_push && q_full);
   assign full          = s1_valid_ff && s1_needs_push && q_full;
   assign accept        = push && !full;

   always_comb begin
      col_start = frame_start ? '0 : col_ff;
      row_start = frame_start ? '0 : row_ff;
      wrap_c    = WW'(col_start) >= eff_w;
      row_adv   = wrap_c ? ({1'b0, row_start} + (ROW_W+1)'(1)) : {1'b0, row_start};
      cur_row   = (row_adv >= {1'b0, eff_h}) ? '0 : row_adv[ROW_W-1:0];
      cur_col   = wrap_c ? '0 : col_start;

      col_inc   = WW'(cur_col) + WW'(1);
      end_row   = col_inc >= eff_w;
      row_inc   = {1'b0, cur_row} + (ROW_W+1)'(1);
      if (end_row) begin
         col_in = '0;
         row_in = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];
      end else begin
         col_in = col_inc[CW-1:0];
         row_in = cur_row;
      end

      last_col = WW'(cur_col) == (eff_w - WW'(1));
      last_row = cur_row == (eff_h - ROW_W'(1));
      fwd_in   = s1_valid_ff && s1_adv && (s1_col_ff == cur_col);
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
         win_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            col_ff    <= col_in;
            row_ff    <= row_in;
            s1_fwd_ff <= fwd_in;
         end
         if (s1_adv) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff       <= pixel_in;
         s1_row_ff       <= cur_row;
         s1_col_ff       <= cur_col;
         s1_int_ff       <= (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2));
         s1_border_ff    <= (cur_row == '0) || last_row || (cur_col == '0) || last_col;
         s1_corner_ff    <= last_row && last_col;
         s1_fwd_older_ff <= s1_mid;
         s1_fwd_newer_ff <= s1_pix_ff;
      end
   end

   c3cif_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_mid, s1_pix_ff}),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (rd_data)
   );

   assign s1_top = s1_fwd_ff ? s1_fwd_older_ff : rd_data[2*PIX_W-1:PIX_W];
   assign s1_mid = s1_fwd_ff ? s1_fwd_newer_ff : rd_data[PIX_W-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = s1_top;
      win_in[1][2] = s1_mid;
      win_in[2][2] = s1_pix_ff;
   end

   assign col_ext = XW'(s1_col_ff);

   always_comb begin
      q_wr.push            = s1_valid_ff && s1_needs_push && !q_full;
      q_wr.item.win        = win_in;
      q_wr.item.pix        = s1_pix_ff;
      q_wr.item.row        = s1_row_ff;
      q_wr.item.col        = col_ext[COL_W-1:0];
      q_wr.item.has_int    = s1_int_ff;
      q_wr.item.has_border = s1_border_ff;
      q_wr.item.corner     = s1_corner_ff;
   end

endmodule

// File: src/c3cif_queue.sv
`include "conv3x3_clamped_image_filter_defines.svh"

module c3cif_queue import c3cif_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  qwrite_type q_wr,
   output logic       q_full,
   output qread_type  q_rd,
   input  logic       q_pop
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   item_type        mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   head_ff, tail_ff;
   logic [NW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign q_full     = count_ff == NW'(QUEUE_DEPTH);
   assign q_rd.valid = count_ff != '0;
   assign q_rd.item  = mem_ff[head_ff];
   assign do_push    = q_wr.push && !q_full;
   assign do_pop     = q_pop && q_rd.valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            tail_ff <= (tail_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PW'(1);
         end
         if (do_pop) begin
            head_ff <= (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= q_wr.item;
      end
   end

   `CCF_ASSERT(a_no_push_when_full, !(q_wr.push && q_full), "front pushed into a full queue")
   `CCF_ASSERT(a_no_pop_when_empty, !(q_pop && !q_rd.valid), "back popped an empty queue")

endmodule

// File: src/c3cif_back.sv
`include "conv3x3_clamped_image_filter_defines.svh"

module c3cif_back import c3cif_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  qread_type         q_rd,
   output logic              q_pop,
   input  kernel_type        kernel,
   output logic              empty,
   input  logic              pop,
   output logic [PIX_W-1:0]  pixel_out,
   output logic [ROW_W-1:0]  out_row,
   output logic [COL_W-1:0]  out_column,
   output logic              last_of_run,
   output logic              frame_done
);

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             has_int;
      logic             has_border;
      logic             corner;
   } meta_type;

   logic signed [PROD_W-1:0] prod_in  [3][3];
   logic signed [PROD_W-1:0] prod_ff  [3][3];
   logic signed [RSUM_W-1:0] rsum_in  [3];
   logic signed [RSUM_W-1:0] rsum_ff  [3];
   logic signed [SUM_W-1:0]  total;
   logic [PIX_W-1:0]         conv_in, conv_ff;

   meta_type meta_in, meta_a_ff, meta_b_ff, meta_c_ff;
   logic     va_ff, vb_ff, vc_ff;
   logic     ready_a, ready_b, ready_c;
   logic     sub_ff, sub_in;
   logic     two, show_int, last_now, take_last;

   assign meta_in = '{pix: q_rd.item.pix, row: q_rd.item.row, col: q_rd.item.col,
                      has_int: q_rd.item.has_int, has_border: q_rd.item.has_border,
                      corner: q_rd.item.corner};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(kernel[i][j]) * $signed({1'b0, q_rd.item.win[i][j]});
         end
      end
      for (int i = 0; i < 3; i++) begin
         rsum_in[i] = RSUM_W'(prod_ff[i][0]) + RSUM_W'(prod_ff[i][1])
                    + RSUM_W'(prod_ff[i][2]);
      end
      total = SUM_W'(rsum_ff[0]) + SUM_W'(rsum_ff[1]) + SUM_W'(rsum_ff[2]);
      if (total[SUM_W-1]) begin
         conv_in = '0;
      end else if (|total[SUM_W-2:FRAC_W+PIX_W]) begin
         conv_in = PIX_MAX;
      end else begin
         conv_in = total[FRAC_W+PIX_W-1:FRAC_W];
      end
   end

   assign two       = meta_c_ff.has_int && meta_c_ff.has_border;
   assign show_int  = meta_c_ff.has_int && !sub_ff;
   assign last_now  = !two || sub_ff;
   assign take_last = vc_ff && pop && last_now;
   assign ready_c   = !vc_ff || take_last;
   assign ready_b   = !vb_ff || ready_c;
   assign ready_a   = !va_ff || ready_b;
   assign q_pop     = q_rd.valid && ready_a;

   always_comb begin
      sub_in = sub_ff;
      if (take_last) begin
         sub_in = 1'b0;
      end else if (vc_ff && pop) begin
         sub_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
         vc_ff  <= 1'b0;
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         if (ready_a) begin
            va_ff <= q_rd.valid;
         end
         if (ready_b) begin
            vb_ff <= va_ff;
         end
         if (ready_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && q_rd.valid) begin
         prod_ff   <= prod_in;
         meta_a_ff <= meta_in;
      end
      if (ready_b && va_ff) begin
         rsum_ff   <= rsum_in;
         meta_b_ff <= meta_a_ff;
      end
      if (ready_c && vb_ff) begin
         conv_ff   <= conv_in;
         meta_c_ff <= meta_b_ff;
      end
   end

   assign empty       = !vc_ff;
   assign pixel_out   = show_int ? conv_ff : meta_c_ff.pix;
   assign out_row     = show_int ? (meta_c_ff.row - ROW_W'(1)) : meta_c_ff.row;
   assign out_column  = show_int ? (meta_c_ff.col - COL_W'(1)) : meta_c_ff.col;
   assign last_of_run = last_now;
   assign frame_done  = last_now && !show_int && meta_c_ff.corner;

   `CCF_ASSERT_IMPL(a_second_only_for_pairs, sub_ff, vc_ff && two,
      "second transfer pending on an item with one result")
   `CCF_ASSERT_NEXT(a_pair_stays, vc_ff && pop && two && !sub_ff, vc_ff && sub_ff,
      "border transfer lost after interior transfer")

endmodule

// File: src/conv3x3_clamped_image_filter.sv
// Channel   Ports                                        Transfer when
// input     push, full, req_pixel_in, req_frame_start   push && !full
// result    empty, pop, rsp_*                           pop && !empty
// config    psel, penable, pwrite, paddr, pwdata, ...   psel && penable && pwrite
//
// One pixel is taken per cycle while full is low, and results drain at one
// per cycle while pop is held. A pixel that yields both an interior and a
// border result holds the output for two transfers, which sets the peak
// pixel rate at those columns. A pixel reaches its first result through
// line store read, window shift, queue, products, row sums, final sum and
// clamp. Reset is synchronous; the line stores need no clearing pass.
module conv3x3_clamped_image_filter import c3cif_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [PIX_W-1:0]  req_pixel_in,
   input  logic              req_frame_start,
   output logic              empty,
   input  logic              pop,
   output logic [PIX_W-1:0]  rsp_pixel_out,
   output logic [ROW_W-1:0]  rsp_out_row,
   output logic [COL_W-1:0]  rsp_out_column,
   output logic              rsp_last_of_run,
   output logic              rsp_frame_done,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [5:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   localparam int CROW_W = 3 * COEF_W;

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_COEF_TOP     = 3'd2;
   localparam logic [2:0] CSR_COEF_MID     = 3'd3;
   localparam logic [2:0] CSR_COEF_BOT     = 3'd4;

   localparam logic [FW_W-1:0]   FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [ROW_W-1:0]  FRAME_HEIGHT_RESET = 16'd1024;
   localparam logic [CROW_W-1:0] COEF_MID_RESET     = 48'h0000_0100_0000;

   logic [FW_W-1:0]   frame_width_ff;
   logic [ROW_W-1:0]  frame_height_ff;
   logic [CROW_W-1:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic              csr_write;
   logic [2:0]        csr_index;
   kernel_type        kernel;
   qwrite_type        q_wr;
   qread_type         q_rd;
   logic              q_full, q_pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         coef_top_ff     <= '0;
         coef_mid_ff     <= COEF_MID_RESET;
         coef_bot_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= pwdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= pwdata[ROW_W-1:0];
            CSR_COEF_TOP:     coef_top_ff     <= pwdata[CROW_W-1:0];
            CSR_COEF_MID:     coef_mid_ff     <= pwdata[CROW_W-1:0];
            CSR_COEF_BOT:     coef_bot_ff     <= pwdata[CROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_FRAME_WIDTH:  prdata = 64'(frame_width_ff);
         CSR_FRAME_HEIGHT: prdata = 64'(frame_height_ff);
         CSR_COEF_TOP:     prdata = 64'(coef_top_ff);
         CSR_COEF_MID:     prdata = 64'(coef_mid_ff);
         CSR_COEF_BOT:     prdata = 64'(coef_bot_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         kernel[0][j] = coef_top_ff[j*COEF_W +: COEF_W];
         kernel[1][j] = coef_mid_ff[j*COEF_W +: COEF_W];
         kernel[2][j] = coef_bot_ff[j*COEF_W +: COEF_W];
      end
   end

   c3cif_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .pixel_in     (req_pixel_in),
      .frame_start  (req_frame_start),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .q_full       (q_full),
      .q_wr         (q_wr)
   );

   c3cif_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   c3cif_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_rd        (q_rd),
      .q_pop       (q_pop),
      .kernel      (kernel),
      .empty       (empty),
      .pop         (pop),
      .pixel_out   (rsp_pixel_out),
      .out_row     (rsp_out_row),
      .out_column  (rsp_out_column),
      .last_of_run (rsp_last_of_run),
      .frame_done  (rsp_frame_done)
   );

endmodule
